FILE: hdl/frls_pkg.sv
// FASTA record length statistics: shared types, constants and helpers.
// Used by fasta_record_length_stats_core. No dependencies.
package frls_pkg;

	localparam int unsigned COUNT_WIDTH = 32;
	localparam int unsigned OUT_WIDTH   = 32;

	localparam logic [7:0] HEADER_MARK  = 8'd62;
	localparam logic [7:0] NEWLINE_BYTE = 8'd10;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;
	typedef logic [OUT_WIDTH-1:0]   out_t;

	localparam cnt_t COUNT_MAX = '1;

	typedef struct packed {
		cnt_t long_len;
		cnt_t long_ord;
		cnt_t short_len;
		cnt_t short_ord;
	} best_t;

	function automatic cnt_t sat_inc(input cnt_t v);
		return (v == COUNT_MAX) ? v : v + cnt_t'(1);
	endfunction

	// Fold a finished record into the bests; hc is the header count so far.
	function automatic best_t close_rec(input best_t b, input cnt_t cur, input cnt_t hc);
		best_t r;
		cnt_t  ord;
		logic  first;
		r     = b;
		ord   = hc - cnt_t'(1);
		first = (ord == '0);
		if (first || cur > b.long_len) begin
			r.long_len = cur;
			r.long_ord = ord;
		end
		if (first || cur < b.short_len) begin
			r.short_len = cur;
			r.short_ord = ord;
		end
		return r;
	endfunction

	function automatic out_t to_out(input cnt_t v);
		logic [63:0] w;
		w = 64'(v);
		return w[OUT_WIDTH-1:0];
	endfunction

endpackage

FILE: hdl/fasta_record_length_stats_core.sv
// Latency: the end-of-file request passes the input register and then the result register before result valid.
// Throughput: one byte per cycle when not stalled; an input register and a result register bracket
// a single pass of compares and saturating counter updates.
// The input register stalls only while a result waits and the downstream is not ready.
// Reset (arst_n low, asynchronous) clears all counters and bests; each result also
// returns the block to its reset state so the next byte starts a new file.
module fasta_record_length_stats_core
	import frls_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
	input  logic         s_axis_tlast,   // end_of_file
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [31:0] record_count, [63:32] longest_length, [95:64] longest_ordinal,
	// [127:96] shortest_length, [159:128] shortest_ordinal, [191:160] total_length
	output logic [191:0] m_axis_tdata,
	output logic         m_axis_tuser    // has_records
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;

	logic  line_start_q, in_header_q, header_seen_q;
	cnt_t  cur_len_q, hdr_cnt_q, total_q;
	best_t best_q;

	logic  line_start_n, in_header_n, header_seen_n;
	cnt_t  cur_len_n, hdr_cnt_n, total_n;
	best_t best_n, best_fin;

	logic  proc;
	logic  out_valid_q;
	logic [191:0] out_data_q;
	logic  out_user_q;

	localparam best_t BEST_RST = '{long_len: '0, long_ord: '0,
		short_len: COUNT_MAX, short_ord: '0};

	assign proc          = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			eof_s1  <= s_axis_tlast;
		end
	end

	always_comb begin
		line_start_n  = line_start_q;
		in_header_n   = in_header_q;
		header_seen_n = header_seen_q;
		cur_len_n     = cur_len_q;
		hdr_cnt_n     = hdr_cnt_q;
		total_n       = total_q;
		best_n        = best_q;
		if (line_start_q && byte_s1 == HEADER_MARK) begin
			if (header_seen_q) begin
				best_n = close_rec(best_q, cur_len_q, hdr_cnt_q);
			end
			hdr_cnt_n     = sat_inc(hdr_cnt_q);
			header_seen_n = 1'b1;
			cur_len_n     = '0;
			in_header_n   = 1'b1;
			line_start_n  = 1'b0;
		end else if (byte_s1 == NEWLINE_BYTE) begin
			in_header_n  = 1'b0;
			line_start_n = 1'b1;
		end else begin
			line_start_n = 1'b0;
			if (!in_header_q) begin
				total_n = sat_inc(total_q);
				if (header_seen_q) begin
					cur_len_n = sat_inc(cur_len_q);
				end
			end
		end
		// end of file closes the open record as well
		best_fin = header_seen_n ? close_rec(best_n, cur_len_n, hdr_cnt_n) : best_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_start_q  <= 1'b1;
			in_header_q   <= 1'b0;
			header_seen_q <= 1'b0;
			cur_len_q     <= '0;
			hdr_cnt_q     <= '0;
			total_q       <= '0;
			best_q        <= BEST_RST;
		end else if (proc) begin
			if (eof_s1) begin
				line_start_q  <= 1'b1;
				in_header_q   <= 1'b0;
				header_seen_q <= 1'b0;
				cur_len_q     <= '0;
				hdr_cnt_q     <= '0;
				total_q       <= '0;
				best_q        <= BEST_RST;
			end else begin
				line_start_q  <= line_start_n;
				in_header_q   <= in_header_n;
				header_seen_q <= header_seen_n;
				cur_len_q     <= cur_len_n;
				hdr_cnt_q     <= hdr_cnt_n;
				total_q       <= total_n;
				best_q        <= best_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && eof_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && eof_s1) begin
			out_user_q <= header_seen_n;
			out_data_q <= {to_out(total_n),
				header_seen_n ? to_out(best_fin.short_ord) : '0,
				header_seen_n ? to_out(best_fin.short_len) : '0,
				header_seen_n ? to_out(best_fin.long_ord)  : '0,
				header_seen_n ? to_out(best_fin.long_len)  : '0,
				to_out(hdr_cnt_n)};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	a_eof_result: assert property (@(posedge clk) disable iff (!arst_n)
		proc && eof_s1 |=> m_axis_tvalid)
		else $error("end of file did not produce a result");

	a_hdr_count: assert property (@(posedge clk) disable iff (!arst_n)
		!header_seen_q |-> hdr_cnt_q == '0)
		else $error("header count nonzero with no header seen");

	a_ordinal: assert property (@(posedge clk) disable iff (!arst_n)
		header_seen_q |-> best_q.long_ord < hdr_cnt_q && best_q.short_ord < hdr_cnt_q)
		else $error("best ordinal beyond header count");

	a_line_state: assert property (@(posedge clk) disable iff (!arst_n)
		in_header_q |-> !line_start_q)
		else $error("header line flagged at line start");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_axis_tready |=> valid_s1 && $stable(eof_s1))
		else $error("stalled request lost");

endmodule
